// ===== rtl/hll_pkg.sv =====
// Shared types and constants for the HyperLogLog sketch.
// Used by every module under rtl/; depends on nothing.
`default_nettype none

package hll_pkg;

   localparam int HLL_P_DEF     = 10;
   localparam int HLL_IDX_MAX_W = 14;
   localparam int HLL_RANK_W    = 5;
   localparam int HLL_EST_W     = 42;
   localparam int HLL_ZREG_W    = 11;

   localparam logic [63:0] HLL_MIX_GOLD = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] HLL_MIX_C1   = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] HLL_MIX_C2   = 64'h94D049BB133111EB;

   localparam logic [HLL_EST_W-1:0] HLL_EST_MAX = '1;
   // ln(2) in Q28 and Q26
   localparam logic [27:0] HLL_LN2_Q28 = 28'd186065280;
   localparam logic [27:0] HLL_LN2_Q26 = 28'd46516320;

   typedef enum logic [1:0] {
      HLL_CMD_INSERT = 2'd0,
      HLL_CMD_MERGE  = 2'd1,
      HLL_CMD_QUERY  = 2'd2,
      HLL_CMD_CLEAR  = 2'd3
   } hll_cmd_type;

   typedef struct packed {
      hll_cmd_type                 kind;
      logic [HLL_IDX_MAX_W-1:0]    idx;
      logic [HLL_RANK_W-1:0]       rank;
   } hll_op_type;

   typedef enum logic [1:0] {F_IDLE, F_MUL, F_FIN, F_PUSH} hll_front_state_type;

   typedef enum logic [2:0] {
      B_SWEEP, B_IDLE, B_MOD, B_SUM, B_SUMLAST, B_ESTGO, B_EST, B_OUT
   } hll_back_state_type;

   typedef enum logic [2:0] {
      E_IDLE, E_DIV, E_DECIDE, E_NORM, E_SQ, E_MULLO, E_MULHI, E_FIN
   } hll_est_state_type;

endpackage

`default_nettype wire

// ===== rtl/hll_front.sv =====
// Front end: takes commands, hashes insert keys (splitmix64 finalizer on one
// shared 32x32 multiplier), and hands decoded ops to the queue. Uses hll_pkg.
`default_nettype none

module hll_front import hll_pkg::*; #(
   parameter int PRECISION_BITS = HLL_P_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // cmd
   input  wire logic [79:0] req_tdata,   // key[63:0], merge_index[73:64], merge_rank[78:74]
   output logic             op_valid,
   input  wire logic        op_ready,
   output hll_op_type       op
);

   localparam logic [HLL_RANK_W-1:0] RANK_CAP = HLL_RANK_W'(33 - PRECISION_BITS);

   hll_front_state_type state_ff, state_in;
   logic [63:0] val_ff, val_in, acc_ff, acc_in, prod_ff, prod_in;
   logic [1:0]  step_ff, step_in;
   logic        round_ff, round_in;
   hll_op_type  op_ff, op_in;

   logic [63:0] mix_a, mix_b, mul_p;
   logic [31:0] ma, mb, hash;
   logic [HLL_RANK_W-1:0] rank_v, mrank;

   always_comb begin
      mix_a = round_ff ? (val_ff ^ (val_ff >> 27)) : (val_ff ^ (val_ff >> 30));
      mix_b = round_ff ? HLL_MIX_C2 : HLL_MIX_C1;
      // low 64 bits of a 64x64 product from three partial products
      case (step_ff)
         2'd0: begin
            ma = mix_a[31:0];
            mb = mix_b[31:0];
         end
         2'd1: begin
            ma = mix_a[31:0];
            mb = mix_b[63:32];
         end
         default: begin
            ma = mix_a[63:32];
            mb = mix_b[31:0];
         end
      endcase
      mul_p = {32'd0, ma} * {32'd0, mb};

      hash = val_ff[31:0] ^ val_ff[62:31];
      rank_v = RANK_CAP;
      for (int i = 31; i >= 0; i--) begin
         if ((i < int'(RANK_CAP) - 1) && hash[i]) rank_v = HLL_RANK_W'(i + 1);
      end
      mrank = (req_tdata[78:74] > RANK_CAP) ? RANK_CAP : req_tdata[78:74];
   end

   always_comb begin
      state_in   = state_ff;
      val_in     = val_ff;
      acc_in     = acc_ff;
      prod_in    = prod_ff;
      step_in    = step_ff;
      round_in   = round_ff;
      op_in      = op_ff;
      req_tready = 1'b0;
      op_valid   = 1'b0;
      case (state_ff)
         F_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in.kind = hll_cmd_type'(req_tuser);
               op_in.idx  = HLL_IDX_MAX_W'(req_tdata[73:64]);
               op_in.rank = mrank;
               if (hll_cmd_type'(req_tuser) == HLL_CMD_INSERT) begin
                  val_in   = req_tdata[63:0] + HLL_MIX_GOLD;
                  step_in  = 2'd0;
                  round_in = 1'b0;
                  state_in = F_MUL;
               end else begin
                  state_in = F_PUSH;
               end
            end
         end
         F_MUL: begin
            prod_in = mul_p;
            step_in = step_ff + 2'd1;
            case (step_ff)
               2'd1: acc_in = prod_ff;
               2'd2: acc_in = acc_ff + (prod_ff << 32);
               2'd3: begin
                  val_in  = acc_ff + (prod_ff << 32);
                  step_in = 2'd0;
                  if (round_ff) begin
                     state_in = F_FIN;
                  end else begin
                     round_in = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         F_FIN: begin
            op_in.idx  = HLL_IDX_MAX_W'(hash[31 -: PRECISION_BITS]);
            op_in.rank = rank_v;
            state_in   = F_PUSH;
         end
         F_PUSH: begin
            op_valid = 1'b1;
            if (op_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      val_ff   <= val_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      step_ff  <= step_in;
      round_ff <= round_in;
      op_ff    <= op_in;
   end

   assign op = op_ff;

endmodule

`default_nettype wire

// ===== rtl/hll_fifo.sv =====
// Two-entry op queue between front end and back end.
// Uses hll_pkg for the op type.
`default_nettype none

module hll_fifo import hll_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  in_valid,
   output logic       in_ready,
   input  hll_op_type in_op,
   output logic       out_valid,
   input  wire logic  out_ready,
   output hll_op_type out_op
);

   hll_op_type slot_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   always_comb begin
      in_ready  = (count_ff != 2'd2);
      out_valid = (count_ff != 2'd0);
      push      = in_valid && in_ready;
      pop       = out_valid && out_ready;
      wptr_in   = wptr_ff ^ push;
      rptr_in   = rptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      out_op    = slot_ff[rptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) slot_ff[wptr_ff] <= in_op;
   end

endmodule

`default_nettype wire

// ===== rtl/hll_est.sv =====
// Estimate unit: serial divide alpha*m^2/sum, fixed-point log2 by repeated
// squaring, range corrections and saturation. Uses hll_pkg.
`default_nettype none

module hll_est import hll_pkg::*; #(
   parameter int PRECISION_BITS = HLL_P_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [PRECISION_BITS+32:0]  sum,
   input  wire logic [PRECISION_BITS:0]     tally,
   output logic                             done,
   output logic [HLL_EST_W-1:0]             value
);

   localparam int SW = PRECISION_BITS + 33;
   localparam logic [127:0] ANUM = (128'(7213) << (3 * PRECISION_BITS)) << 32;
   localparam logic [127:0] ADEN =
      128'(10) * (128'(1000) * (128'(1) << PRECISION_BITS) + 128'(1079));
   localparam logic [63:0] ALPHA = 64'(ANUM / ADEN);
   localparam logic [71:0] NUMER = {ALPHA, 8'd0};
   localparam logic [63:0] SMALL_LIM = 64'(640) << PRECISION_BITS;

   function automatic logic [HLL_EST_W-1:0] sat(input logic [63:0] v);
      sat = (v > 64'(HLL_EST_MAX)) ? HLL_EST_MAX : v[HLL_EST_W-1:0];
   endfunction

   hll_est_state_type state_ff, state_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic [SW-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [63:0]   quo_ff, quo_in, acc_ff, acc_in;
   logic [40:0]   x_ff, x_in;
   logic [5:0]    k_ff, k_in;
   logic [29:0]   frac_ff, frac_in;
   logic          small_ff, small_in, done_ff, done_in;
   logic [45:0]   prod_ff, prod_in;
   logic [HLL_EST_W-1:0] val_ff, val_in;

   logic [SW:0]   r2;
   logic [68:0]   q30;
   logic [61:0]   sq;
   logic [31:0]   y;
   logic [35:0]   diff;
   logic [27:0]   kc;
   logic [63:0]   t;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      acc_in   = acc_ff;
      x_in     = x_ff;
      k_in     = k_ff;
      frac_in  = frac_ff;
      small_in = small_ff;
      prod_in  = prod_ff;
      val_in   = val_ff;
      done_in  = 1'b0;

      r2   = {rem_ff, NUMER[cnt_ff]};
      q30  = {quo_ff, 5'd0} - {4'd0, quo_ff, 1'b0};
      sq   = {31'd0, x_ff[30:0]} * {31'd0, x_ff[30:0]};
      y    = sq[61:30];
      diff = (small_ff ? (36'(PRECISION_BITS) << 30) : (36'(40) << 30)) - {k_ff, frac_ff};
      kc   = small_ff ? HLL_LN2_Q28 : HLL_LN2_Q26;
      t    = acc_ff + (64'(prod_ff) << 18);

      case (state_ff)
         E_IDLE: begin
            if (start) begin
               den_in   = sum;
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = 7'd71;
               state_in = E_DIV;
            end
         end
         E_DIV: begin
            // one quotient bit per cycle, restoring
            if (r2 >= {1'b0, den_ff}) begin
               rem_in = SW'(r2 - {1'b0, den_ff});
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = SW'(r2);
               quo_in = {quo_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd0) state_in = E_DECIDE;
         end
         E_DECIDE: begin
            k_in = 6'd40;
            if (quo_ff <= SMALL_LIM) begin
               if (tally != '0) begin
                  x_in     = 41'(tally);
                  small_in = 1'b1;
                  state_in = E_NORM;
               end else begin
                  val_in   = sat(quo_ff);
                  done_in  = 1'b1;
                  state_in = E_IDLE;
               end
            end else if (q30 > (69'(1) << 40)) begin
               if (quo_ff >= (64'(1) << 40)) begin
                  val_in   = HLL_EST_MAX;
                  done_in  = 1'b1;
                  state_in = E_IDLE;
               end else begin
                  x_in     = 41'((64'(1) << 40) - quo_ff);
                  small_in = 1'b0;
                  state_in = E_NORM;
               end
            end else begin
               val_in   = sat(quo_ff);
               done_in  = 1'b1;
               state_in = E_IDLE;
            end
         end
         E_NORM: begin
            // shift until the leading one sits at bit 40; k tracks its position
            if (x_ff[40]) begin
               x_in     = 41'(x_ff[40:10]);
               frac_in  = '0;
               cnt_in   = 7'd29;
               state_in = E_SQ;
            end else begin
               x_in = x_ff << 1;
               k_in = k_ff - 6'd1;
            end
         end
         E_SQ: begin
            frac_in = {frac_ff[28:0], y[31]};
            x_in    = y[31] ? 41'(y[31:1]) : 41'(y[30:0]);
            cnt_in  = cnt_ff - 7'd1;
            if (cnt_ff == 7'd0) state_in = E_MULLO;
         end
         E_MULLO: begin
            prod_in  = {28'd0, diff[17:0]} * {18'd0, kc};
            state_in = E_MULHI;
         end
         E_MULHI: begin
            acc_in   = 64'(prod_ff);
            prod_in  = {28'd0, diff[35:18]} * {18'd0, kc};
            state_in = E_FIN;
         end
         E_FIN: begin
            val_in   = small_ff ? sat(t >> (50 - PRECISION_BITS)) : sat(t >> 16);
            done_in  = 1'b1;
            state_in = E_IDLE;
         end
         default: state_in = E_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff   <= cnt_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      acc_ff   <= acc_in;
      x_ff     <= x_in;
      k_ff     <= k_in;
      frac_ff  <= frac_in;
      small_ff <= small_in;
      prod_ff  <= prod_in;
      val_ff   <= val_in;
   end

   assign done  = done_ff;
   assign value = val_ff;

endmodule

`default_nettype wire

// ===== rtl/hll_back.sv =====
// Back end: rank register memory, read-modify-write for insert and merge,
// clearing sweep, register walk for queries, result register. Uses hll_pkg.
`default_nettype none

module hll_back import hll_pkg::*; #(
   parameter int PRECISION_BITS = HLL_P_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        op_valid,
   output logic                             op_ready,
   input  hll_op_type                       op,
   output logic                             est_start,
   output logic [PRECISION_BITS+32:0]       est_sum,
   output logic [PRECISION_BITS:0]          est_tally,
   input  wire logic                        est_done,
   input  wire logic [HLL_EST_W-1:0]        est_value,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [55:0]                      rsp_tdata
);

   localparam int M  = 1 << PRECISION_BITS;
   localparam int SW = PRECISION_BITS + 33;
   localparam int AW = PRECISION_BITS;

   logic [HLL_RANK_W-1:0] rank_mem [M];
   logic [HLL_RANK_W-1:0] rd_ff;

   hll_back_state_type state_ff, state_in;
   logic [AW-1:0]  addr_ff, addr_in;
   hll_op_type     op_ff, op_in;
   logic [AW:0]    tally_ff, tally_in;
   logic [SW-1:0]  sum_ff, sum_in;
   logic           rdv_ff, rdv_in, clr_ff, clr_in;
   logic [HLL_EST_W-1:0] res_est_ff, res_est_in;
   logic           res_grew_ff, res_grew_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [55:0]    rsp_data_ff, rsp_data_in;

   logic [AW-1:0]  raddr, waddr;
   logic           we;
   logic [HLL_RANK_W-1:0] wdata;
   logic           slot_free;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      op_in        = op_ff;
      tally_in     = tally_ff;
      sum_in       = sum_ff;
      rdv_in       = 1'b0;
      clr_in       = clr_ff;
      res_est_in   = res_est_ff;
      res_grew_in  = res_grew_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      op_ready     = 1'b0;
      est_start    = 1'b0;
      we           = 1'b0;
      waddr        = addr_ff;
      wdata        = '0;
      raddr        = op.idx[AW-1:0];
      slot_free    = !rsp_valid_ff || rsp_tready;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      // register walk: add 2^(32 - rank) as read data comes back
      if (rdv_ff) sum_in = sum_ff + (SW'(1) << (6'd32 - 6'(rd_ff)));

      case (state_ff)
         B_SWEEP: begin
            we      = 1'b1;
            addr_in = addr_ff + AW'(1);
            if (addr_ff == '1) begin
               tally_in    = (AW + 1)'(M);
               res_est_in  = '0;
               res_grew_in = 1'b0;
               clr_in      = 1'b0;
               state_in    = clr_ff ? B_OUT : B_IDLE;
            end
         end
         B_IDLE: begin
            op_ready = 1'b1;
            if (op_valid) begin
               op_in = op;
               case (op.kind)
                  HLL_CMD_INSERT, HLL_CMD_MERGE: state_in = B_MOD;
                  HLL_CMD_QUERY: begin
                     addr_in  = '0;
                     sum_in   = '0;
                     state_in = B_SUM;
                  end
                  HLL_CMD_CLEAR: begin
                     addr_in  = '0;
                     clr_in   = 1'b1;
                     state_in = B_SWEEP;
                  end
                  default: state_in = B_IDLE;
               endcase
            end
         end
         B_MOD: begin
            waddr       = op_ff.idx[AW-1:0];
            wdata       = op_ff.rank;
            res_est_in  = '0;
            res_grew_in = 1'b0;
            if (op_ff.rank > rd_ff) begin
               we          = 1'b1;
               res_grew_in = 1'b1;
               if (rd_ff == '0 && tally_ff != '0) tally_in = tally_ff - (AW + 1)'(1);
            end
            state_in = B_OUT;
         end
         B_SUM: begin
            raddr   = addr_ff;
            rdv_in  = 1'b1;
            addr_in = addr_ff + AW'(1);
            if (addr_ff == '1) state_in = B_SUMLAST;
         end
         B_SUMLAST: state_in = B_ESTGO;
         B_ESTGO: begin
            est_start = 1'b1;
            state_in  = B_EST;
         end
         B_EST: begin
            if (est_done) begin
               res_est_in  = est_value;
               res_grew_in = 1'b0;
               state_in    = B_OUT;
            end
         end
         B_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'd0, HLL_ZREG_W'(tally_ff), res_grew_ff, res_est_ff};
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) rank_mem[waddr] <= wdata;
      rd_ff <= rank_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_SWEEP;
         addr_ff      <= '0;
         clr_ff       <= 1'b0;
         tally_ff     <= (AW + 1)'(M);
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         clr_ff       <= clr_in;
         tally_ff     <= tally_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      sum_ff      <= sum_in;
      res_est_ff  <= res_est_in;
      res_grew_ff <= res_grew_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign est_sum    = sum_ff;
   assign est_tally  = tally_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/hyperloglog_sketch_top.sv =====
// Top level of the HyperLogLog sketch: front end, op queue, back end, estimate unit.
// Depends on hll_pkg, hll_front, hll_fifo, hll_back, hll_est.
`default_nettype none

// HyperLogLog cardinality sketch with 2^PRECISION_BITS five-bit rank registers.
// Commands arrive on req_tuser (0 insert key, 1 merge one register, 2 query,
// 3 clear); one result transfer follows every command, in order. The front end
// accepts a command whenever it holds none: an insert is hashed on a single
// 32x32 multiplier, and a two-entry queue lets it run ahead of the back end.
// In the back end insert and merge do a read-modify-write of the rank memory,
// a query walks the memory at one register per cycle and then runs the estimate
// unit (72-step divide, up to 40 normalize steps, 30 squaring steps). Clear,
// and the pass that follows reset, write one register per cycle; the front end
// keeps accepting commands meanwhile until the queue fills.

module hyperloglog_sketch_top import hll_pkg::*; #(
   parameter int PRECISION_BITS = HLL_P_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // cmd
   input  wire logic [79:0] req_tdata,   // key[63:0], merge_index[73:64], merge_rank[78:74]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata    // estimate[41:0], grew[42], zero_registers[53:43]
);

   hll_op_type fr_op, bk_op;
   logic fr_valid, fr_ready, bk_valid, bk_ready;
   logic est_start, est_done;
   logic [PRECISION_BITS+32:0] est_sum;
   logic [PRECISION_BITS:0]    est_tally;
   logic [HLL_EST_W-1:0]       est_value;

   hll_front #(.PRECISION_BITS(PRECISION_BITS)) u_front (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tuser, .req_tdata,
      .op_valid(fr_valid), .op_ready(fr_ready), .op(fr_op)
   );

   hll_fifo u_fifo (
      .clock, .reset,
      .in_valid(fr_valid), .in_ready(fr_ready), .in_op(fr_op),
      .out_valid(bk_valid), .out_ready(bk_ready), .out_op(bk_op)
   );

   hll_back #(.PRECISION_BITS(PRECISION_BITS)) u_back (
      .clock, .reset,
      .op_valid(bk_valid), .op_ready(bk_ready), .op(bk_op),
      .est_start, .est_sum, .est_tally, .est_done, .est_value,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   hll_est #(.PRECISION_BITS(PRECISION_BITS)) u_est (
      .clock, .reset,
      .start(est_start), .sum(est_sum), .tally(est_tally),
      .done(est_done), .value(est_value)
   );

   // a result that raised a register never carries an estimate
   a_grew_no_est: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[42] |-> rsp_tdata[41:0] == '0)
      else $error("grew set with nonzero estimate");

   a_tally_range: assert property (@(posedge clock) disable iff (reset)
      est_tally <= (PRECISION_BITS + 1)'(1 << PRECISION_BITS))
      else $error("zero tally above register count");

   // done comes only after the serial divide, so it never follows start directly
   a_est_latency: assert property (@(posedge clock) disable iff (reset)
      est_start |=> !est_done)
      else $error("estimate done too early");

endmodule

`default_nettype wire

// ===== tb/sv/tb_hyperloglog_sketch_top.sv =====
// Self-checking testbench for hyperloglog_sketch_top: streams insert, merge, query and
// clear commands and checks every result against an in-bench sketch predictor.
// Depends on hll_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb_hyperloglog_sketch_top;
   import hll_pkg::*;

   localparam int PBITS    = 10;
   localparam int NREGS    = 1 << PBITS;
   localparam int RANK_CAP = 33 - PBITS;
   localparam longint unsigned LN2_Q28 = 64'd186065280;
   localparam longint unsigned LN2_Q26 = 64'd46516320;

   typedef struct {
      hll_cmd_type  cmd;
      logic [63:0]  key;
      logic [9:0]   idx;
      logic [4:0]   rank;
   } sketch_cmd_type;

   typedef struct {
      logic [41:0] estimate;
      logic        grew;
      logic [10:0] zero_regs;
   } sketch_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [79:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;

   hyperloglog_sketch_top #(.PRECISION_BITS(PBITS)) dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tuser, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [4:0]  rank_regs [NREGS];
   int unsigned zero_count;

   sketch_cmd_type pending_cmds[$];
   sketch_rsp_type expected_rsps[$];
   sketch_cmd_type in_flight;
   int          total_cmds;
   int          sent = 0;
   int          received = 0;
   int          mismatches = 0;
   int          n_query = 0, n_sat = 0, n_large = 0, n_grew = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;

   function automatic logic [63:0] mix_key(logic [63:0] v);
      logic [63:0] r;
      r = v + HLL_MIX_GOLD;
      r = (r ^ (r >> 30)) * HLL_MIX_C1;
      r = (r ^ (r >> 27)) * HLL_MIX_C2;
      return r ^ (r >> 31);
   endfunction

   // log2 with 30 fraction bits, v >= 1
   function automatic logic [127:0] log2_q30(logic [127:0] v);
      int unsigned k;
      logic [127:0] x, frac;
      k = 0;
      frac = 0;
      for (int i = 0; i < 64; i++)
         if (v[i]) k = i;
      x = (k > 30) ? (v >> (k - 30)) : (v << (30 - k));
      for (int i = 0; i < 30; i++) begin
         x = (x * x) >> 30;
         frac = frac << 1;
         if (x >= (128'd1 << 31)) begin
            x = x >> 1;
            frac = frac | 1;
         end
      end
      return (128'(k) << 30) | frac;
   endfunction

   function automatic logic [41:0] sketch_estimate();
      logic [127:0] m, s, alpha, e, t;
      m = NREGS;
      s = 0;
      for (int i = 0; i < NREGS; i++) s += 128'd1 << (32 - rank_regs[i]);
      alpha = ((128'd7213 * m * m * m) << 32) / (128'd10 * (128'd1000 * m + 128'd1079));
      e = (alpha << 8) / s;
      if (e <= 128'd640 * m) begin
         if (zero_count > 0) begin
            t = ((128'(PBITS) << 30) - log2_q30(zero_count)) * LN2_Q28;
            e = t >> (50 - PBITS);
         end
      end else if (128'd30 * e > (128'd1 << 40)) begin
         n_large++;
         if (e >= (128'd1 << 40)) begin
            n_sat++;
            return HLL_EST_MAX;
         end
         t = ((128'd40 << 30) - log2_q30((128'd1 << 40) - e)) * LN2_Q26;
         e = t >> 16;
      end
      return (e > 128'(HLL_EST_MAX)) ? HLL_EST_MAX : e[41:0];
   endfunction

   function automatic logic raise_rank(logic [9:0] idx, logic [4:0] rank);
      if (rank > rank_regs[idx]) begin
         if (rank_regs[idx] == 0 && zero_count > 0) zero_count--;
         rank_regs[idx] = rank;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void clear_sketch();
      foreach (rank_regs[i]) rank_regs[i] = '0;
      zero_count = NREGS;
   endfunction

   function automatic sketch_rsp_type apply_cmd(sketch_cmd_type c);
      sketch_rsp_type r;
      logic [31:0] h;
      logic [4:0]  rk;
      r = '{default: '0};
      case (c.cmd)
         HLL_CMD_INSERT: begin
            h = 32'(mix_key(c.key));
            rk = 5'd1;
            while (rk < RANK_CAP && h[rk-1] == 1'b0) rk++;
            r.grew = raise_rank(h[31 -: PBITS], rk);
         end
         HLL_CMD_MERGE: begin
            rk = (c.rank > RANK_CAP) ? 5'(RANK_CAP) : c.rank;
            r.grew = raise_rank(c.idx, rk);
         end
         HLL_CMD_QUERY: begin
            r.estimate = sketch_estimate();
            n_query++;
         end
         default: clear_sketch();
      endcase
      r.zero_regs = zero_count[10:0];
      return r;
   endfunction

   function automatic void add_cmd(hll_cmd_type cmd, logic [63:0] key, logic [9:0] idx,
                                   logic [4:0] rank);
      sketch_cmd_type c;
      c.cmd = cmd;
      c.key = key;
      c.idx = idx;
      c.rank = rank;
      pending_cmds.push_back(c);
   endfunction

   function automatic sketch_cmd_type random_cmd();
      sketch_cmd_type c;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      c.key = {$urandom, $urandom};
      c.idx = 10'($urandom_range(0, NREGS - 1));
      c.rank = 5'($urandom_range(0, 31));
      if (pick < 55) c.cmd = HLL_CMD_INSERT;
      else if (pick < 88) c.cmd = HLL_CMD_MERGE;
      else if (pick < 96) c.cmd = HLL_CMD_QUERY;
      else c.cmd = HLL_CMD_CLEAR;
      return c;
   endfunction

   // idling pattern moves through three phases as the run progresses
   function automatic bit sender_idles();
      if (sent < total_cmds / 3) return $urandom_range(0, 99) < 10;
      if (sent < 2 * total_cmds / 3) return $urandom_range(0, 99) < 84;
      return 1'b0;
   endfunction

   function automatic bit receiver_idles();
      if (sent < total_cmds / 3) return $urandom_range(0, 99) < 84;
      if (sent < 2 * total_cmds / 3) return $urandom_range(0, 99) < 10;
      return 1'b0;
   endfunction

   // driver: predicts each command at the transfer that accepts it
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(apply_cmd(in_flight));
            sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_cmds.size() > 0 && !sender_idles()) begin
               in_flight = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= in_flight.cmd;
               req_tdata <= {1'b0, in_flight.rank, in_flight.idx, in_flight.key};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so the internal queue fills and input stalls
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && sent == 120) begin
         hold_done <= 1'b1;
         hold_left <= 3000;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      sketch_rsp_type want;
      logic [41:0] got_est;
      logic        got_grew;
      logic [10:0] got_zr;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_est = rsp_tdata[41:0];
            got_grew = rsp_tdata[42];
            got_zr = rsp_tdata[53:43];
            received++;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected result transfer est=%0h grew=%0b zero=%0d",
                           got_est, got_grew, got_zr);
            end else begin
               want = expected_rsps.pop_front();
               if (want.grew) n_grew++;
               if (got_est !== want.estimate || got_grew !== want.grew ||
                   got_zr !== want.zero_regs) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("ERROR: rsp %0d exp/got: est %0h/%0h grew %0b/%0b zero %0d/%0d",
                              received, want.estimate, got_est, want.grew, got_grew,
                              want.zero_regs, got_zr);
               end
            end
         end
         rsp_tready <= (hold_left == 0) && !receiver_idles();
      end
   end

   initial begin
      clear_sketch();
      // directed: empty query, key extremes, merge clamps, no-grow, clear
      add_cmd(HLL_CMD_QUERY, '0, '0, '0);
      add_cmd(HLL_CMD_INSERT, 64'h0, '0, '0);
      add_cmd(HLL_CMD_INSERT, '1, '1, '1);
      add_cmd(HLL_CMD_INSERT, '1, '0, '0);
      add_cmd(HLL_CMD_MERGE, '0, 10'd5, 5'd0);
      add_cmd(HLL_CMD_MERGE, '1, 10'd1023, 5'd31);
      add_cmd(HLL_CMD_MERGE, '0, 10'd1023, 5'd24);
      add_cmd(HLL_CMD_MERGE, '0, 10'd0, 5'd1);
      add_cmd(HLL_CMD_MERGE, '0, 10'd0, 5'd1);
      add_cmd(HLL_CMD_MERGE, '0, 10'd512, 5'd23);
      add_cmd(HLL_CMD_MERGE, '0, 10'd511, 5'd16);
      add_cmd(HLL_CMD_QUERY, '0, '0, '0);
      add_cmd(HLL_CMD_CLEAR, '0, '0, '0);
      add_cmd(HLL_CMD_QUERY, '0, '0, '0);
      add_cmd(HLL_CMD_INSERT, 64'h8000_0000_0000_0000, '0, '0);
      add_cmd(HLL_CMD_INSERT, 64'h0000_0000_0000_0001, '0, '0);
      add_cmd(HLL_CMD_QUERY, '0, '0, '0);
      for (int i = 0; i < 180; i++) pending_cmds.push_back(random_cmd());
      // fill most registers so the last query returns the raw estimate, not linear counting
      add_cmd(HLL_CMD_CLEAR, '0, '0, '0);
      for (int i = 0; i < 760; i++) begin
         add_cmd(HLL_CMD_MERGE, {$urandom, $urandom}, 10'(i), 5'($urandom_range(14, 21)));
         if (i % 256 == 255) add_cmd(HLL_CMD_QUERY, '0, '0, '0);
      end
      add_cmd(HLL_CMD_QUERY, '0, '0, '0);
      total_cmds = pending_cmds.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (!(pending_cmds.size() == 0 && sent == total_cmds && expected_rsps.size() == 0))
         @(posedge clock);
      repeat (1400) @(posedge clock);
      $display("Covered %0d commands: %0d queries (%0d large-range, %0d saturated), %0d raises.",
               total_cmds, n_query, n_large, n_sat, n_grew);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("ERROR: timeout with %0d results outstanding", expected_rsps.size());
      $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/hll_pkg.sv
rtl/hll_front.sv
rtl/hll_fifo.sv
rtl/hll_est.sv
rtl/hll_back.sv
rtl/hyperloglog_sketch_top.sv
tb/sv/tb_hyperloglog_sketch_top.sv
